### src/cc4_pkg.sv
// ----------------------------------------------------------------------------
// cc4_pkg
// shared constants and baseline tables of the four-input cross-correlator
// ----------------------------------------------------------------------------
package cc4_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned PROD_BITS     = 2 * SAMPLE_BITS + 1;
  localparam int unsigned NBASE         = 10;
  localparam int unsigned BASE_BITS     = 4;
  localparam int unsigned CFG_BITS      = 20;
  localparam int unsigned CHAN_OUT_BITS = 10;
  localparam int unsigned VIS_BITS      = 32;
  localparam int unsigned CHANNELS_DEF  = 1024;
  localparam int unsigned ACC_BITS_DEF  = 32;

  localparam logic [BASE_BITS-1:0] LAST_BASE = BASE_BITS'(NBASE - 1);

  // antenna pair of each baseline: autos first, then crosses
  localparam logic [1:0] PAIR_A [NBASE] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                            2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [NBASE] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                            2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

### src/cc4_front.sv
// ----------------------------------------------------------------------------
// cc4_front
// accepts samples, forms the ten products, accumulates per channel in the
// row memory and hands finished rows of a dump frame to the queue
// ----------------------------------------------------------------------------
module cc4_front import cc4_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned ACC_BITS = ACC_BITS_DEF,
  localparam int unsigned CW      = $clog2(CHANNELS),
  localparam int unsigned ROW_W   = NBASE * 2 * ACC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] ant_re_i [4],
  input  logic signed [SAMPLE_BITS-1:0] ant_im_i [4],
  input  logic [CFG_BITS-1:0]           frames_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [CW-1:0]                 push_chan_o,
  output logic [ROW_W-1:0]              push_row_o
);

  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  logic [ROW_W-1:0] mem [CHANNELS];

  logic                 clr_active_q;
  logic [CW-1:0]        clr_addr_q;
  logic [CW-1:0]        ch_q, ch_d;
  logic [CFG_BITS-1:0]  frame_q, frame_d;
  logic                 s1_valid_q;
  logic                 s1_dump_q;
  logic [CW-1:0]        s1_ch_q;
  logic [ROW_W-1:0]     rd_q;
  logic signed [PROD_BITS-1:0] pr_d [NBASE];
  logic signed [PROD_BITS-1:0] pi_d [NBASE];
  logic signed [PROD_BITS-1:0] s1_pr_q [NBASE];
  logic signed [PROD_BITS-1:0] s1_pi_q [NBASE];
  logic [NBASE-1:0][1:0][ACC_BITS-1:0] rd_row;
  logic [NBASE-1:0][1:0][ACC_BITS-1:0] sum_row;
  logic [CFG_BITS-1:0]  need;
  logic                 dump;
  logic                 accept;
  logic                 s1_adv;

  assign need   = (frames_i == '0) ? CFG_BITS'(1) : frames_i;
  assign dump   = ({1'b0, frame_q} + (CFG_BITS + 1)'(1)) >= {1'b0, need};
  assign s1_adv = s1_valid_q && (!s1_dump_q || push_ready_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign accept = in_valid_i && !in_stall_o;

  for (genvar k = 0; k < NBASE; k++) begin : g_prod
    localparam int unsigned A = PAIR_A[k];
    localparam int unsigned B = PAIR_B[k];
    logic signed [63:0] pr_ext, pi_ext;
    assign pr_d[k] = ant_re_i[A] * ant_re_i[B] + ant_im_i[A] * ant_im_i[B];
    assign pi_d[k] = ant_im_i[A] * ant_re_i[B] - ant_re_i[A] * ant_im_i[B];
    assign pr_ext  = 64'(s1_pr_q[k]);
    assign pi_ext  = 64'(s1_pi_q[k]);
    assign sum_row[k][0] = rd_row[k][0] + pr_ext[ACC_BITS-1:0];
    assign sum_row[k][1] = rd_row[k][1] + pi_ext[ACC_BITS-1:0];
  end

  assign rd_row = rd_q;

  always_comb begin
    ch_d    = ch_q;
    frame_d = frame_q;
    if (accept) begin
      if (ch_q == LAST_CH) begin
        ch_d    = '0;
        frame_d = dump ? '0 : frame_q + CFG_BITS'(1);
      end else begin
        ch_d = ch_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      ch_q         <= '0;
      frame_q      <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + CW'(1);
        if (clr_addr_q == LAST_CH) begin
          clr_active_q <= 1'b0;
        end
      end
      ch_q    <= ch_d;
      frame_q <= frame_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q   <= ch_q;
      s1_dump_q <= dump;
      s1_pr_q   <= pr_d;
      s1_pi_q   <= pi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[ch_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem[clr_addr_q] <= '0;
    end else if (s1_adv) begin
      mem[s1_ch_q] <= s1_dump_q ? '0 : sum_row;
    end
  end

  assign push_valid_o = s1_valid_q && s1_dump_q;
  assign push_chan_o  = s1_ch_q;
  assign push_row_o   = sum_row;

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q)
    else $error("item in flight during clearing pass");

  a_chan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ch_q != LAST_CH |=> ch_q == $past(ch_q) + CW'(1))
    else $error("channel counter did not advance");

  a_held_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_ch_q))
    else $error("stalled accumulate stage lost its item");

endmodule

### src/cc4_queue.sv
// ----------------------------------------------------------------------------
// cc4_queue
// two-entry queue of dumped channel rows between front and back
// ----------------------------------------------------------------------------
module cc4_queue import cc4_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 && (cnt_q == 2'd0 || cnt_q == 2'd1 || wr_q == rd_q))
    else $error("queue count out of step with pointers");

endmodule

### src/cc4_back.sv
// ----------------------------------------------------------------------------
// cc4_back
// takes one dumped row at a time and sends its ten visibilities out
// ----------------------------------------------------------------------------
module cc4_back import cc4_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned ACC_BITS = ACC_BITS_DEF,
  localparam int unsigned CW      = $clog2(CHANNELS),
  localparam int unsigned ROW_W   = NBASE * 2 * ACC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  logic [CW-1:0]            pop_chan_i,
  input  logic [ROW_W-1:0]         pop_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CHAN_OUT_BITS-1:0] chan_index_o,
  output logic [BASE_BITS-1:0]     baseline_o,
  output logic [VIS_BITS-1:0]      vis_re_o,
  output logic [VIS_BITS-1:0]      vis_im_o,
  output logic                     last_of_item_o,
  output logic                     last_of_dump_o
);

  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  logic                                hold_valid_q;
  logic [CW-1:0]                       hold_ch_q;
  logic [NBASE-1:0][1:0][ACC_BITS-1:0] hold_row_q;
  logic [BASE_BITS-1:0]                k_q;
  logic                                out_valid_q;
  logic                                slot_free, load, last_k;
  logic signed [ACC_BITS-1:0]          acc_re, acc_im;
  logic signed [63:0]                  ext_re, ext_im;
  logic [31:0]                         ch_ext;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign load        = hold_valid_q && slot_free;
  assign last_k      = (k_q == LAST_BASE);
  assign pop_ready_o = !hold_valid_q || (load && last_k);

  assign acc_re = hold_row_q[k_q][0];
  assign acc_im = hold_row_q[k_q][1];
  assign ext_re = 64'(acc_re);
  assign ext_im = 64'(acc_im);
  assign ch_ext = 32'(hold_ch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_valid_i && pop_ready_o) begin
        hold_valid_q <= 1'b1;
        k_q          <= '0;
      end else if (load) begin
        k_q <= k_q + BASE_BITS'(1);
        if (last_k) hold_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      hold_ch_q  <= pop_chan_i;
      hold_row_q <= pop_row_i;
    end
    if (load) begin
      chan_index_o   <= ch_ext[CHAN_OUT_BITS-1:0];
      baseline_o     <= k_q;
      vis_re_o       <= ext_re[VIS_BITS-1:0];
      vis_im_o       <= ext_im[VIS_BITS-1:0];
      last_of_item_o <= last_k;
      last_of_dump_o <= last_k && (hold_ch_q == LAST_CH);
    end
  end

  assign out_valid_o = out_valid_q;

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> k_q <= LAST_BASE)
    else $error("baseline counter past last baseline");

  a_k_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !last_k |=> hold_valid_q && k_q == $past(k_q) + BASE_BITS'(1))
    else $error("baseline skipped");

endmodule

### src/four_input_cross_correlator_top.sv
// ----------------------------------------------------------------------------
// four_input_cross_correlator_top
// four-antenna x engine: per-channel accumulation of ten visibilities
//
//   channel  signals                             direction
//   in       in_valid_i / in_stall_o, ant*_i     sample request in
//   out      out_valid_o / out_stall_i, *_o      visibility request out
//   cfg      cfg_valid_i / cfg_ready_o, cfg_data_i  integration_frames write
//
// one sample request per cycle outside dump frames; products and the channel
// row read are registered, then sums are written back to the row memory
// in a dump frame each request yields ten results at one per cycle while
// out_stall_i is low, so there the output port sets the request rate
// after reset a clearing pass zeroes every row of the memory, in_stall_o
// high throughout
// a two-row queue lets accumulation run ahead of a stalled output
// ----------------------------------------------------------------------------
module four_input_cross_correlator_top import cc4_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] ant0_re_i,
  input  logic signed [SAMPLE_BITS-1:0] ant0_im_i,
  input  logic signed [SAMPLE_BITS-1:0] ant1_re_i,
  input  logic signed [SAMPLE_BITS-1:0] ant1_im_i,
  input  logic signed [SAMPLE_BITS-1:0] ant2_re_i,
  input  logic signed [SAMPLE_BITS-1:0] ant2_im_i,
  input  logic signed [SAMPLE_BITS-1:0] ant3_re_i,
  input  logic signed [SAMPLE_BITS-1:0] ant3_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CHAN_OUT_BITS-1:0]      chan_index_o,
  output logic [BASE_BITS-1:0]          baseline_o,
  output logic signed [VIS_BITS-1:0]    vis_re_o,
  output logic signed [VIS_BITS-1:0]    vis_im_o,
  output logic                          last_of_item_o,
  output logic                          last_of_dump_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_BITS-1:0]           cfg_data_i
);

  localparam int unsigned CW    = $clog2(CHANNELS);
  localparam int unsigned ROW_W = NBASE * 2 * ACC_BITS;

  logic [CFG_BITS-1:0]          frames_q;
  logic signed [SAMPLE_BITS-1:0] ant_re [4];
  logic signed [SAMPLE_BITS-1:0] ant_im [4];
  logic                         push_valid, push_ready, pop_valid, pop_ready;
  logic [CW-1:0]                push_chan, pop_chan;
  logic [ROW_W-1:0]             push_row, pop_row;
  logic [VIS_BITS-1:0]          vis_re, vis_im;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CFG_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_q <= cfg_data_i;
    end
  end

  assign ant_re = '{ant0_re_i, ant1_re_i, ant2_re_i, ant3_re_i};
  assign ant_im = '{ant0_im_i, ant1_im_i, ant2_im_i, ant3_im_i};

  cc4_front #(.CHANNELS(CHANNELS), .ACC_BITS(ACC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .ant_re_i(ant_re), .ant_im_i(ant_im), .frames_i(frames_q),
    .push_valid_o(push_valid), .push_ready_i(push_ready),
    .push_chan_o(push_chan), .push_row_o(push_row)
  );

  cc4_queue #(.WIDTH(CW + ROW_W)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready),
    .push_data_i({push_chan, push_row}),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready),
    .pop_data_o({pop_chan, pop_row})
  );

  cc4_back #(.CHANNELS(CHANNELS), .ACC_BITS(ACC_BITS)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready),
    .pop_chan_i(pop_chan), .pop_row_i(pop_row),
    .out_valid_o, .out_stall_i, .chan_index_o, .baseline_o,
    .vis_re_o(vis_re), .vis_im_o(vis_im), .last_of_item_o, .last_of_dump_o
  );

  assign vis_re_o = vis_re;
  assign vis_im_o = vis_im;

endmodule

### dv/four_input_cross_correlator_top_tb.sv
// ----------------------------------------------------------------------------
// four_input_cross_correlator_top_tb
// streams four-antenna samples through several integration settings and
// checks every visibility against a per-channel accumulation model, with
// random gaps on the sample side and random stalls on the result side
// ----------------------------------------------------------------------------
module four_input_cross_correlator_top_tb import cc4_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_BITS-1:0] ant_set_t [8];

  typedef struct packed {
    logic [CHAN_OUT_BITS-1:0] chan;
    logic [BASE_BITS-1:0]     base;
    logic [VIS_BITS-1:0]      re;
    logic [VIS_BITS-1:0]      im;
    logic                     last_item;
    logic                     last_dump;
  } vis_t;

  class vis_scoreboard;
    bit [VIS_BITS-1:0] sum_re [CHANNELS_DEF][NBASE];
    bit [VIS_BITS-1:0] sum_im [CHANNELS_DEF][NBASE];
    int unsigned       chan;
    int unsigned       frames_done;
    bit [CFG_BITS-1:0] frames_cfg;
    vis_t              due [$];
    int                errors;

    function new();
      chan        = 0;
      frames_done = 0;
      frames_cfg  = 1;
      errors      = 0;
    endfunction

    function void set_frames(bit [CFG_BITS-1:0] v);
      frames_cfg = v;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_sample(ant_set_t s);
      longint      re [4];
      longint      im [4];
      longint      pr, pi;
      int unsigned need;
      bit          dump;
      vis_t        v;
      int          a, b;
      need = (frames_cfg == 0) ? 1 : frames_cfg;
      dump = (frames_done + 1) >= need;
      for (int k = 0; k < 4; k++) begin
        re[k] = s[2*k];
        im[k] = s[2*k+1];
      end
      for (int k = 0; k < NBASE; k++) begin
        a = PAIR_A[k];
        b = PAIR_B[k];
        pr = re[a] * re[b] + im[a] * im[b];
        pi = im[a] * re[b] - re[a] * im[b];
        sum_re[chan][k] = sum_re[chan][k] + pr[VIS_BITS-1:0];
        sum_im[chan][k] = sum_im[chan][k] + pi[VIS_BITS-1:0];
        if (dump) begin
          v.chan      = chan[CHAN_OUT_BITS-1:0];
          v.base      = k[BASE_BITS-1:0];
          v.re        = sum_re[chan][k];
          v.im        = sum_im[chan][k];
          v.last_item = (k == NBASE - 1);
          v.last_dump = (k == NBASE - 1) && (chan == CHANNELS_DEF - 1);
          due.push_back(v);
          sum_re[chan][k] = '0;
          sum_im[chan][k] = '0;
        end
      end
      if (chan == CHANNELS_DEF - 1) begin
        chan = 0;
        frames_done = dump ? 0 : ((frames_done + 1) & 32'hFFFFF);
      end else begin
        chan++;
      end
    endfunction

    function void check_result(vis_t got);
      vis_t exp_v;
      if (due.size() == 0) begin
        report($sformatf("unexpected result chan %0d base %0d", got.chan, got.base));
        return;
      end
      exp_v = due.pop_front();
      if (got.chan != exp_v.chan) report($sformatf("chan exp %0d got %0d",
                                                   exp_v.chan, got.chan));
      if (got.base != exp_v.base) report($sformatf("baseline exp %0d got %0d",
                                                   exp_v.base, got.base));
      if (got.re != exp_v.re) report($sformatf("vis_re exp %h got %h ch %0d bl %0d",
                                               exp_v.re, got.re, exp_v.chan, exp_v.base));
      if (got.im != exp_v.im) report($sformatf("vis_im exp %h got %h ch %0d bl %0d",
                                               exp_v.im, got.im, exp_v.chan, exp_v.base));
      if (got.last_item != exp_v.last_item) report($sformatf("last_of_item exp %0b got %0b",
                                                             exp_v.last_item, got.last_item));
      if (got.last_dump != exp_v.last_dump) report($sformatf("last_of_dump exp %0b got %0b",
                                                             exp_v.last_dump, got.last_dump));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] ant_i [8];
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [CHAN_OUT_BITS-1:0]      chan_index_o;
  logic [BASE_BITS-1:0]          baseline_o;
  logic signed [VIS_BITS-1:0]    vis_re_o;
  logic signed [VIS_BITS-1:0]    vis_im_o;
  logic                          last_of_item_o;
  logic                          last_of_dump_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_BITS-1:0]           cfg_data_i;

  vis_scoreboard sb;
  bit            calm;

  four_input_cross_correlator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ant0_re_i      (ant_i[0]),
    .ant0_im_i      (ant_i[1]),
    .ant1_re_i      (ant_i[2]),
    .ant1_im_i      (ant_i[3]),
    .ant2_re_i      (ant_i[4]),
    .ant2_im_i      (ant_i[5]),
    .ant3_re_i      (ant_i[6]),
    .ant3_im_i      (ant_i[7]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chan_index_o   (chan_index_o),
    .baseline_o     (baseline_o),
    .vis_re_o       (vis_re_o),
    .vis_im_o       (vis_im_o),
    .last_of_item_o (last_of_item_o),
    .last_of_dump_o (last_of_dump_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("four_input_cross_correlator_top_tb failed");
    $finish;
  end

  // result side: check accepted results, then pick the next stall
  always @(posedge clk_i) begin
    vis_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{chan_index_o, baseline_o, vis_re_o, vis_im_o, last_of_item_o,
              last_of_dump_o};
      sb.check_result(got);
    end
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
  end

  task automatic send_sample(ant_set_t s);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 34) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int k = 0; k < 8; k++) ant_i[k] <= s[k];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
  endtask

  task automatic send_random(int n);
    ant_set_t s;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 7))
          0:       s[k] = 16'sh7FFF;
          1:       s[k] = 16'sh8000;
          2:       s[k] = '0;
          default: s[k] = SAMPLE_BITS'($urandom());
        endcase
      end
      send_sample(s);
    end
  endtask

  task automatic write_frames(bit [CFG_BITS-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_frames(v);
  endtask

  initial begin
    ant_set_t s;
    int       wait_cycles;
    sb          = new();
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    for (int k = 0; k < 8; k++) ant_i[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero acts as one: every channel dumps
    write_frames('0);
    for (int d = 0; d < 12; d++) begin
      for (int k = 0; k < 8; k++) begin
        case (d)
          0:       s[k] = '0;
          1:       s[k] = 16'sh7FFF;
          2:       s[k] = 16'sh8000;
          3:       s[k] = k[0] ? 16'sh8000 : 16'sh7FFF;
          4:       s[k] = k[0] ? 16'sh7FFF : 16'sh8000;
          5:       s[k] = (k == 0) ? 16'sh8000 : '0;
          6:       s[k] = (k == 3) ? 16'sh7FFF : '0;
          7:       s[k] = (k == 5) ? 16'sh8000 : 16'sh0001;
          8:       s[k] = 16'shFFFF;
          9:       s[k] = (k < 4) ? 16'sh8000 : 16'sh7FFF;
          10:      s[k] = 16'sh5555;
          default: s[k] = 16'shAAAA;
        endcase
      end
      send_sample(s);
    end
    send_random(13);

    // largest setting: accumulate without dumping
    write_frames(20'hFFFFF);
    send_random(150);
    write_frames(20'd3);
    send_random(100);

    // dump every channel again, first with no idling
    write_frames(20'd1);
    calm = 1'b1;
    send_random(60);
    calm = 1'b0;
    send_random(70);
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.due.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("four_input_cross_correlator_top_tb passed");
    end else begin
      $display("four_input_cross_correlator_top_tb failed");
    end
    $finish;
  end

endmodule
